// ----- rtl/core/mavg_pkg.sv -----
// shared constants for the moving average window block
package mavg_pkg;

  // default sizing of the sample ring and the sample word
  localparam int MAX_DEPTH_DEF   = 32;
  localparam int SAMPLE_BITS_DEF = 16;

  // window size register
  localparam int             WIN_W     = 6;
  localparam logic [WIN_W-1:0] WIN_RESET = 6'd32;

  // entries in the queue between front and back
  localparam int QUEUE_DEPTH = 2;

endpackage

// ----- rtl/core/mavg_ram.sv -----
// generic single-write, single-read ram with registered read data
module mavg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/core/mavg_queue.sv -----
// small fifo that decouples the front classifier from the back datapath
module mavg_queue #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    used;

  assign full     = (used == CW'(DEPTH));
  assign empty    = (used == '0);
  assign pop_data = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      used   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        used <= used + 1'b1;
      end else if (pop && !push) begin
        used <= used - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/mavg_front.sv -----
// front end: accepts samples, tracks ring position and fill, tags each item
module mavg_front import mavg_pkg::*; #(
  parameter int MAX_DEPTH   = MAX_DEPTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int PTR_W       = 5,
  parameter int CNT_W       = 6,
  parameter int ENT_W       = SAMPLE_BITS + PTR_W + 1 + CNT_W
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [WIN_W-1:0]       cfg_window,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  output logic                   push,
  output logic [ENT_W-1:0]       push_data,
  input  logic                   queue_full
);

  localparam int CMP_W = (WIN_W > CNT_W) ? WIN_W : CNT_W;

  logic [WIN_W-1:0] window;
  logic [PTR_W-1:0] pos;
  logic [CNT_W-1:0] held;
  logic [CMP_W-1:0] win_ext;
  logic [CNT_W-1:0] win;
  logic             replace;
  logic [CNT_W-1:0] count_out;

  // effective window: zero acts as one, large values clamp to the ring depth
  always_comb begin
    win_ext = CMP_W'(window);
    if (win_ext == '0) begin
      win = CNT_W'(1);
    end else if (win_ext > CMP_W'(MAX_DEPTH)) begin
      win = CNT_W'(MAX_DEPTH);
    end else begin
      win = CNT_W'(win_ext);
    end
  end

  // classify: warm-up adds, full window replaces the oldest sample
  assign replace   = (held == win);
  assign count_out = replace ? held : held + 1'b1;
  assign in_ready  = !queue_full;
  assign push      = in_valid && in_ready;
  assign push_data = {count_out, replace, pos, in_sample};

  // window register, position and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      window <= WIN_RESET;
      pos    <= '0;
      held   <= '0;
    end else if (cfg_write) begin
      window <= cfg_window;
      pos    <= '0;
      held   <= '0;
    end else if (push) begin
      held <= count_out;
      pos  <= (CNT_W'(pos) == win - 1'b1) ? '0 : pos + 1'b1;
    end
  end

`ifndef SYNTHESIS
  // fill count never passes the window
  assert property (@(posedge clk) disable iff (rst) held <= win)
    else $error("fill count above window");

  // write position stays inside the window
  assert property (@(posedge clk) disable iff (rst) CNT_W'(pos) < win)
    else $error("ring position outside window");
`endif

endmodule

// ----- rtl/core/mavg_back.sv -----
// back end: ring update, running sum and serial divide for the average
module mavg_back import mavg_pkg::*; #(
  parameter int MAX_DEPTH   = MAX_DEPTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int PTR_W       = 5,
  parameter int CNT_W       = 6,
  parameter int ENT_W       = SAMPLE_BITS + PTR_W + 1 + CNT_W
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic                          queue_empty,
  input  logic [ENT_W-1:0]              queue_data,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_average,
  output logic [CNT_W-1:0]              out_fill
);

  localparam int SUM_W  = SAMPLE_BITS + ((MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 0);
  localparam int STEP_W = $clog2(SUM_W);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_READ = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_SIGN = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  state_t                        state;
  logic signed [SAMPLE_BITS-1:0] smp;
  logic [PTR_W-1:0]              wpos;
  logic                          repl;
  logic [CNT_W-1:0]              cnt;
  logic signed [SUM_W-1:0]       sum;
  logic                          neg;
  logic [CNT_W:0]                rem;
  logic [SUM_W-1:0]              quo;
  logic [STEP_W-1:0]             step;
  logic signed [SAMPLE_BITS-1:0] avg;
  logic [CNT_W-1:0]              fill;

  logic [SAMPLE_BITS-1:0]        ram_rd_data;
  logic signed [SAMPLE_BITS-1:0] old_smp;
  logic signed [SUM_W:0]         sum_calc;
  logic signed [SUM_W-1:0]       sum_new;
  logic [SUM_W-1:0]              mag;
  logic [CNT_W:0]                rem_sh;
  logic [SUM_W-1:0]              q_sgn;

  // queue entry fields
  logic [SAMPLE_BITS-1:0] e_sample;
  logic [PTR_W-1:0]       e_pos;
  logic                   e_repl;
  logic [CNT_W-1:0]       e_cnt;

  assign {e_cnt, e_repl, e_pos, e_sample} = queue_data;

  assign pop = (state == ST_IDLE) && !queue_empty;

  // sample ring
  mavg_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_DEPTH),
    .AW    (PTR_W)
  ) u_ring (
    .clk     (clk),
    .we      (state == ST_READ),
    .wr_addr (wpos),
    .wr_data (smp),
    .rd_en   (pop),
    .rd_addr (e_pos),
    .rd_data (ram_rd_data)
  );

  // sum update: drop the oldest sample once the window is full
  always_comb begin
    old_smp  = signed'(ram_rd_data);
    sum_calc = (SUM_W+1)'(sum) + (SUM_W+1)'(smp)
             - (repl ? (SUM_W+1)'(old_smp) : '0);
    sum_new  = SUM_W'(sum_calc);
    mag      = sum_new[SUM_W-1] ? SUM_W'(-sum_new) : SUM_W'(sum_new);
  end

  // one restoring divide step per cycle on the magnitude
  assign rem_sh = {rem[CNT_W-1:0], quo[SUM_W-1]};
  assign q_sgn  = neg ? -quo : quo;

  assign out_valid   = (state == ST_OUT);
  assign out_average = avg;
  assign out_fill    = fill;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sum   <= '0;
      step  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cfg_write) begin
            sum <= '0;
          end
          if (pop) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          sum   <= sum_new;
          step  <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          step <= step + 1'b1;
          if (step == STEP_W'(SUM_W - 1)) begin
            state <= ST_SIGN;
          end
        end
        ST_SIGN: begin
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (pop) begin
          smp  <= signed'(e_sample);
          wpos <= e_pos;
          repl <= e_repl;
          cnt  <= e_cnt;
        end
      end
      ST_READ: begin
        neg <= sum_new[SUM_W-1];
        quo <= mag;
        rem <= '0;
      end
      ST_DIV: begin
        if (rem_sh >= {1'b0, cnt}) begin
          rem <= rem_sh - {1'b0, cnt};
          quo <= {quo[SUM_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[SUM_W-2:0], 1'b0};
        end
      end
      ST_SIGN: begin
        avg  <= signed'(SAMPLE_BITS'(q_sgn));
        fill <= cnt;
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  // a result always carries a nonzero fill count
  assert property (@(posedge clk) disable iff (rst) out_valid |-> (out_fill != '0))
    else $error("result with empty window");

  // a result appears only after the sign fix-up
  assert property (@(posedge clk) disable iff (rst) $rose(out_valid) |-> $past(state == ST_SIGN))
    else $error("result raised outside divide sequence");

  // a taken result frees the back end for the next entry
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready) |=> (state == ST_IDLE))
    else $error("back end did not return to idle");
`endif

endmodule

// ----- rtl/core/moving_average_window.sv -----
// Moving average over a ring of the most recent signed samples.
//
// s_axis carries one sample per transaction; m_axis returns one result per
// sample: the running sum divided by the fill count (truncated toward zero)
// and the fill count itself. cfg_valid/cfg_ready/cfg_data writes the window
// size (1..MAX_DEPTH; zero acts as one, larger values clamp to MAX_DEPTH);
// every write clears the ring position and fill count, and the running sum
// when the back end is idle. Write it only while no sample is in flight.
//
// Each item is popped from the queue, then the back end updates the ring and
// sum, runs the serial restoring divider (one quotient bit per cycle) on the
// SUM_W = SAMPLE_BITS + clog2(MAX_DEPTH) bit magnitude, fixes the sign and
// presents the result; a new item starts in the back end only once the
// previous result has been taken.
// A two-entry queue lets the front accept samples while the back end works
// or while m_axis is stalled; s_axis_tready drops when the queue is full.
// Reset (rst, synchronous) restores a window of 32 and an empty ring.
module moving_average_window import mavg_pkg::*; #(
  parameter int MAX_DEPTH   = MAX_DEPTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [WIN_W-1:0]                        cfg_data,
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  // sample
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]        s_axis_tdata,
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  // average, fill_count
  output logic [((SAMPLE_BITS+$clog2(MAX_DEPTH+1)+7)/8)*8-1:0] m_axis_tdata
);

  localparam int PTR_W  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int CNT_W  = $clog2(MAX_DEPTH + 1);
  localparam int ENT_W  = SAMPLE_BITS + PTR_W + 1 + CNT_W;
  localparam int OUT_W  = ((SAMPLE_BITS + CNT_W + 7) / 8) * 8;
  localparam int PAD_W  = OUT_W - SAMPLE_BITS - CNT_W;

  logic                          cfg_write;
  logic                          push;
  logic [ENT_W-1:0]              push_data;
  logic                          queue_full;
  logic                          queue_empty;
  logic                          pop;
  logic [ENT_W-1:0]              pop_data;
  logic signed [SAMPLE_BITS-1:0] average;
  logic [CNT_W-1:0]              fill_count;

  // configuration is always taken
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  mavg_front #(
    .MAX_DEPTH   (MAX_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS),
    .PTR_W       (PTR_W),
    .CNT_W       (CNT_W),
    .ENT_W       (ENT_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_window (cfg_data),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_sample  (s_axis_tdata[SAMPLE_BITS-1:0]),
    .push       (push),
    .push_data  (push_data),
    .queue_full (queue_full)
  );

  mavg_queue #(
    .WIDTH (ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (queue_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (queue_empty)
  );

  mavg_back #(
    .MAX_DEPTH   (MAX_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS),
    .PTR_W       (PTR_W),
    .CNT_W       (CNT_W),
    .ENT_W       (ENT_W)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .queue_empty (queue_empty),
    .queue_data  (pop_data),
    .pop         (pop),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_average (average),
    .out_fill    (fill_count)
  );

  // pack result, zero filled to whole bytes
  assign m_axis_tdata = {{PAD_W{1'b0}}, fill_count, average};

endmodule

// ----- sim/moving_average_window_test.sv -----
`timescale 1ns / 100ps
// self-checking testbench for the moving average window block
module moving_average_window_test import mavg_pkg::*;;

  localparam int SAMPLE_W   = SAMPLE_BITS_DEF;
  localparam int RING_DEPTH = MAX_DEPTH_DEF;
  localparam int FILL_W     = $clog2(MAX_DEPTH_DEF + 1);
  localparam int S_TDATA_W  = ((SAMPLE_W + 7) / 8) * 8;
  localparam int M_TDATA_W  = ((SAMPLE_W + FILL_W + 7) / 8) * 8;
  // divider latency plus some slack for the queue in front of it
  localparam int SETTLE_CYCLES = SAMPLE_W + $clog2(MAX_DEPTH_DEF) + 4 + 8;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int IDLE_PCT      = 27;
  localparam int PRINT_CAP     = 40;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] average;
    logic [FILL_W-1:0]          fill_count;
  } avg_result_t;

  typedef enum int {MIX_UNIFORM, MIX_EXTREME, MIX_HIGH_RUN, MIX_LOW_RUN} sample_mix_t;

  // clock, reset and block ports
  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [WIN_W-1:0]     cfg_data = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;   // sample
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;        // average, fill_count

  // stimulus and result bookkeeping
  avg_result_t avg_expected[$];
  int          error_count = 0;
  int          cycle_count = 0;
  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;
  bit          rx_hold_req = 1'b0;
  int          rx_hold_len = 0;
  int          rx_hold_left = 0;

  // predicted window state
  logic [WIN_W-1:0]           win_setting = WIN_RESET;
  logic signed [SAMPLE_W-1:0] win_ring [RING_DEPTH];
  int                         win_sum;
  int                         win_pos;
  int                         win_held;

  moving_average_window u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // empty ring, zero sum, start position
  function void clear_window();
    for (int i = 0; i < RING_DEPTH; i++) win_ring[i] = '0;
    win_sum  = 0;
    win_pos  = 0;
    win_held = 0;
  endfunction

  // update the window with one sample and queue the average it yields
  function void predict_average(input logic signed [SAMPLE_W-1:0] smp);
    int          span;
    avg_result_t res;
    span = win_setting;
    if (span < 1) span = 1;
    if (span > RING_DEPTH) span = RING_DEPTH;
    if (win_pos >= span) win_pos = 0;
    // warm-up only adds, a full window drops its oldest sample first
    if (win_held < span) win_held++;
    else win_sum -= win_ring[win_pos];
    win_ring[win_pos] = smp;
    win_sum += smp;
    win_pos++;
    if (win_pos >= span) win_pos = 0;
    res.average    = SAMPLE_W'(win_sum / win_held);
    res.fill_count = FILL_W'(win_held);
    avg_expected.push_back(res);
  endfunction

  function automatic logic [SAMPLE_W-1:0] random_sample(input sample_mix_t mix);
    logic [SAMPLE_W-1:0] edge_vals [7];
    edge_vals = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001, 16'h8001, 16'h7ffe};
    case (mix)
      MIX_EXTREME: begin
        if ($urandom_range(1)) return edge_vals[$urandom_range(6)];
        return SAMPLE_W'($urandom);
      end
      MIX_HIGH_RUN: begin
        if ($urandom_range(9) != 0) return 16'h7fff;
        return SAMPLE_W'($urandom);
      end
      MIX_LOW_RUN: begin
        if ($urandom_range(9) != 0) return 16'h8000;
        return SAMPLE_W'($urandom);
      end
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic sample_mix_t random_mix();
    int pick;
    pick = $urandom_range(99);
    if (pick < 65) return MIX_UNIFORM;
    if (pick < 80) return MIX_EXTREME;
    if (pick < 90) return MIX_HIGH_RUN;
    return MIX_LOW_RUN;
  endfunction

  // one sample transaction, entered and left at a falling edge
  task automatic send_sample(input logic [SAMPLE_W-1:0] smp);
    while (tx_idle_on && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= S_TDATA_W'(smp);
    do @(posedge clk); while (!s_axis_tready);
    predict_average(smp);
    @(negedge clk);
  endtask

  // stop offering samples until every queued average has come back
  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (avg_expected.size() != 0);
  endtask

  // window write while the block is idle
  task automatic set_window(input logic [WIN_W-1:0] w);
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= w;
    do @(posedge clk); while (!cfg_ready);
    win_setting = w;
    clear_window();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_run(input int count, input sample_mix_t mix);
    repeat (count) send_sample(random_sample(mix));
  endtask

  // output side: random stalls, long hold-offs on request
  always @(negedge clk) begin : result_sink
    if (rx_hold_req) begin
      rx_hold_left = rx_hold_len;
      rx_hold_req  = 1'b0;
    end
    if (rx_hold_left > 0) begin
      m_axis_tready <= 1'b0;
      rx_hold_left--;
    end else if (rx_idle_on) begin
      m_axis_tready <= ($urandom_range(99) >= IDLE_PCT);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // compare each result transaction with the oldest expected average
  always @(posedge clk) begin : result_check
    avg_result_t                want;
    logic signed [SAMPLE_W-1:0] got_avg;
    logic [FILL_W-1:0]          got_fill;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_avg  = m_axis_tdata[SAMPLE_W-1:0];
      got_fill = m_axis_tdata[SAMPLE_W +: FILL_W];
      if (avg_expected.size() == 0) begin
        error_count++;
        if (error_count <= PRINT_CAP)
          $display("%0t: unexpected result, expected none, actual average %0d fill %0d",
                   $time, got_avg, got_fill);
      end else begin
        want = avg_expected.pop_front();
        if (got_avg !== want.average) begin
          error_count++;
          if (error_count <= PRINT_CAP)
            $display("%0t: average mismatch, expected %0d, actual %0d",
                     $time, want.average, got_avg);
        end
        if (got_fill !== want.fill_count) begin
          error_count++;
          if (error_count <= PRINT_CAP)
            $display("%0t: fill_count mismatch, expected %0d, actual %0d",
                     $time, want.fill_count, got_fill);
        end
      end
    end
  end

  // window left at its reset size, extreme samples
  task automatic test_reset_window();
    send_sample(16'h7fff);
    send_sample(16'h8000);
    send_sample(16'hffff);
    send_sample(16'h0001);
    send_sample(16'h0000);
    send_sample(16'h7fff);
  endtask

  // a zero window behaves as a window of one
  task automatic test_window_zero();
    set_window('0);
    send_sample(16'h8000);
    send_sample(16'h7fff);
    send_sample(-16'sd5);
  endtask

  // sizes past the ring depth clamp to it
  task automatic test_window_clamp();
    set_window(6'd63);
    send_sample(16'h8000);
    send_sample(16'h8000);
    send_sample(16'h7fff);
    set_window(6'd33);
    send_sample(16'd100);
    send_sample(-16'sd101);
  endtask

  // negative quotients round toward zero, two-sample then single-sample window
  task automatic test_truncation();
    set_window(6'd2);
    send_sample(-16'sd1);
    send_sample(-16'sd2);
    send_sample(16'd3);
    send_sample(-16'sd4);
    send_sample(16'h7fff);
    send_sample(16'h7fff);
    set_window(6'd1);
    send_sample(16'h8000);
    send_sample(16'h7fff);
  endtask

  // many window sizes, each long enough to wrap the ring
  task automatic test_random_windows();
    int fixed_sizes [10];
    fixed_sizes = '{1, 32, 0, 63, 33, 2, 31, 16, 3, 8};
    foreach (fixed_sizes[i]) begin
      set_window(WIN_W'(fixed_sizes[i]));
      send_run($urandom_range(35, 75), random_mix());
    end
    repeat (14) begin
      set_window(WIN_W'($urandom_range(0, 63)));
      send_run($urandom_range(35, 75), random_mix());
    end
  endtask

  // output held off while samples keep coming, so the input stalls
  task automatic test_output_hold();
    set_window(WIN_W'($urandom_range(4, 32)));
    rx_hold_len = 400;
    rx_hold_req = 1'b1;
    tx_idle_on  = 1'b0;
    send_run(24, MIX_UNIFORM);
    tx_idle_on  = 1'b1;
  endtask

  // sender stops mid-window until all averages are back, then resumes
  task automatic test_sender_pause();
    set_window(6'd32);
    send_run(40, random_mix());
    wait_results_drained();
    send_run(40, random_mix());
  endtask

  // back-to-back traffic with no idling on either side
  task automatic test_no_idle();
    set_window(WIN_W'($urandom_range(1, 32)));
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    send_run(200, MIX_UNIFORM);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  initial begin
    clear_window();
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_reset_window();
    test_window_zero();
    test_window_clamp();
    test_truncation();
    test_random_windows();
    test_output_hold();
    test_sender_pause();
    test_no_idle();
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (error_count == 0 && avg_expected.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/mavg_pkg.sv
rtl/core/mavg_ram.sv
rtl/core/mavg_queue.sv
rtl/core/mavg_front.sv
rtl/core/mavg_back.sv
rtl/core/moving_average_window.sv
sim/moving_average_window_test.sv
